[rtl/ssla_pkg.sv]
package ssla_pkg;

	localparam int unsigned DATA_W  = 8;
	localparam int unsigned COORD_W = 7;
	localparam int unsigned SUM_W   = 9;
	localparam int unsigned CFG_W   = 8;

	localparam logic [CFG_W-1:0] GRID_WIDTH_RESET = 8'd104;

	typedef enum logic {
		KIND_CELL = 1'b0,
		KIND_PAD  = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [DATA_W-1:0]  shade_value;
		logic [DATA_W-1:0]  light_value;
	} in_beat_t;

	typedef struct packed {
		logic [DATA_W-1:0]  light_out;
		logic [COORD_W-1:0] out_column;
		logic [COORD_W-1:0] out_row;
		logic               frame_last;
	} out_beat_t;

	typedef struct packed {
		logic [DATA_W-1:0] south;
		logic [DATA_W-1:0] center;
		logic [DATA_W-1:0] light;
	} cell_data_t;

endpackage

[rtl/ssla_cell.sv]
module ssla_cell #(
	parameter int unsigned MAX_WIDTH = 128,
	parameter int unsigned IDX       = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           shift,
	input  logic [$clog2(MAX_WIDTH):0]     width,
	input  ssla_pkg::cell_data_t           tail,
	input  ssla_pkg::cell_data_t           nbr,
	output ssla_pkg::cell_data_t           data
);
	import ssla_pkg::*;

	localparam int unsigned WW = $clog2(MAX_WIDTH) + 1;

	logic [DATA_W-1:0] south_q;
	logic [DATA_W-1:0] center_q;
	logic [DATA_W-1:0] light_q;
	logic              at_tail;
	logic              before_tail;
	cell_data_t        next;

	// The line is as long as the row: the cell at the row's last column takes the new beat,
	// cells in front of it take their neighbor's data, and cells past it hold.
	assign at_tail     = (width == WW'(IDX + 1));
	assign before_tail = (WW'(IDX + 1) < width);
	assign next        = at_tail ? tail : nbr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			south_q  <= '0;
			center_q <= '0;
		end else if (shift && (at_tail || before_tail)) begin
			south_q  <= next.south;
			center_q <= next.center;
		end
	end

	always_ff @(posedge clk) begin
		if (shift && (at_tail || before_tail)) begin
			light_q <= next.light;
		end
	end

	assign data.south  = south_q;
	assign data.center = center_q;
	assign data.light  = light_q;

endmodule

[rtl/ssla_out_buf.sv]
module ssla_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ssla_pkg::out_beat_t push_data,
	output logic                full,
	output logic                out_valid,
	input  logic                out_stall,
	output ssla_pkg::out_beat_t out_data
);
	import ssla_pkg::*;

	logic      main_v_q;
	logic      skid_v_q;
	out_beat_t main_q;
	out_beat_t skid_q;
	logic      main_free;

	assign main_free = !main_v_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (main_free) begin
			main_v_q <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			main_q <= skid_v_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign full      = skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

endmodule

[rtl/shade_stencil_light_attenuator.sv]
// Light attenuator over a raster stream of grid cells, one cell per beat from the south row up.
// Each cell's light is reduced by center/2 + west/4 + east/8 + north/8 + south/4 of the shade
// grid (off-grid neighbors are zero) and clamped at zero. A cell's result leaves when the cell
// north of it arrives, so results lag one row; pad beats after the last row drain it, and the
// final result of the frame carries frame_last. The block takes one beat per clock unless the
// skid stage is full. The row buffers are shift lines of MAX_WIDTH cells whose length follows
// grid_width; each cell within that length moves one place per beat that is not an ignored pad.
// Results are registered in the output buffer; a skid stage keeps input flowing for one extra
// result while the output is stalled. grid_width is meant to change only between frames.
module shade_stencil_light_attenuator #(
	parameter int unsigned MAX_WIDTH = 128,
	parameter int unsigned MAX_ROWS  = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [7:0]          cfg_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  ssla_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output ssla_pkg::out_beat_t out_data
);
	import ssla_pkg::*;

	localparam int unsigned CW   = $clog2(MAX_WIDTH);
	localparam int unsigned WW   = CW + 1;
	localparam int unsigned RW   = $clog2(MAX_ROWS + 1);
	localparam int unsigned CMPW = (WW > CFG_W) ? WW : CFG_W;

	logic [CFG_W-1:0]  grid_width_q;
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic              drain_q;
	logic [DATA_W-1:0] west_q;

	logic [CMPW-1:0]   gw_ext;
	logic [WW-1:0]     width;
	logic [CW-1:0]     c;
	logic              accept;
	logic              is_pad;
	logic              ignore;
	logic              shift;
	logic              emit;
	logic              last;
	logic              buf_full;
	cell_data_t        line [MAX_WIDTH];
	cell_data_t        head;
	cell_data_t        tail;
	logic [DATA_W-1:0] west;
	logic [DATA_W-1:0] east;
	logic [DATA_W-1:0] north;
	logic [SUM_W-1:0]  sum;
	logic [SUM_W-1:0]  light_ext;
	logic [DATA_W-1:0] value;
	out_beat_t         result;

	assign gw_ext = CMPW'(grid_width_q);

	always_comb begin
		priority if (gw_ext == '0) begin
			width = WW'(1);
		end else if (gw_ext > CMPW'(MAX_WIDTH)) begin
			width = WW'(MAX_WIDTH);
		end else begin
			width = WW'(gw_ext);
		end
	end

	assign c        = ({1'b0, col_q} >= width) ? CW'(width - WW'(1)) : col_q;
	assign last     = (WW'(c) + WW'(1) >= width);
	assign in_stall = buf_full;
	assign accept   = in_valid && !in_stall;
	assign is_pad   = drain_q || (in_data.kind == KIND_PAD) ||
	                  ((row_q >= RW'(MAX_ROWS)) && (c == '0));
	assign ignore   = is_pad && !drain_q && ((row_q == '0) || (c != '0));
	assign shift    = accept && !ignore;
	assign emit     = shift && (is_pad || (row_q != '0));

	assign head  = line[0];
	assign west  = (c != '0) ? west_q : '0;
	assign east  = (WW'(c) + WW'(1) < width) ? line[1].center : '0;
	assign north = is_pad ? '0 : in_data.shade_value;

	assign sum = SUM_W'(head.center >> 1) + SUM_W'(west >> 2) + SUM_W'(east >> 3) +
	             SUM_W'(north >> 3) + SUM_W'(head.south >> 2);
	assign light_ext = SUM_W'(head.light);
	assign value     = (light_ext > sum) ? DATA_W'(light_ext - sum) : '0;

	// While draining, the lines recirculate so that the pending row stays in place.
	always_comb begin
		if (is_pad) begin
			tail = head;
		end else begin
			tail.south  = (row_q != '0) ? head.center : '0;
			tail.center = in_data.shade_value;
			tail.light  = in_data.light_value;
		end
	end

	for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_cell
		cell_data_t nbr;
		if (k == MAX_WIDTH - 1) begin : g_end
			assign nbr = tail;
		end else begin : g_mid
			assign nbr = line[k + 1];
		end
		ssla_cell #(
			.MAX_WIDTH (MAX_WIDTH),
			.IDX       (k)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.width  (width),
			.tail   (tail),
			.nbr    (nbr),
			.data   (line[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= GRID_WIDTH_RESET;
		end else if (cfg_wr_en) begin
			grid_width_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= 1'b0;
		end else if (shift) begin
			if (last) begin
				col_q <= '0;
			end else begin
				col_q <= c + CW'(1);
			end
			if (is_pad) begin
				drain_q <= !last;
				if (last) begin
					row_q <= '0;
				end
			end else if (last) begin
				row_q <= row_q + RW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			west_q <= head.center;
		end
	end

	assign result.light_out  = value;
	assign result.out_column = COORD_W'(c);
	assign result.out_row    = COORD_W'(row_q - RW'(1));
	assign result.frame_last = is_pad && last;

	ssla_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.push_data (result),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
